[design/three_channel_servo_slew_limiter_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the servo slew limiter
// ---------------------------------------------------------------------------
`ifndef THREE_CHANNEL_SERVO_SLEW_LIMITER_TOP_MACROS_SVH
`define THREE_CHANNEL_SERVO_SLEW_LIMITER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising aclk edge, off while aresetn is low
`define TCSSL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication
`define TCSSL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TCSSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`else

`define TCSSL_ASSERT(lbl, prop, msg)
`define TCSSL_ASSERT_IMPL(lbl, ante, cons, msg)
`define TCSSL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/tcssl_pkg.sv]
// ---------------------------------------------------------------------------
// tcssl_pkg
// Types and constants of the three-channel servo slew limiter.
// ---------------------------------------------------------------------------
package tcssl_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int POS_W        = 8;
    localparam int CH_IDX_W     = 2;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 8;

    localparam logic [POS_W-1:0] HOME_POSITION    = 8'd127;
    localparam logic [POS_W-1:0] RESET_INTERVAL   = 8'd20;
    localparam logic [POS_W-1:0] RESET_STEP       = 8'd1;
    localparam logic [POS_W-1:0] RESET_MIN_LIMIT  = 8'd0;
    localparam logic [POS_W-1:0] RESET_MAX_LIMIT  = 8'd255;
    localparam logic [POS_W-1:0] ELAPSED_CEILING  = 8'd255;

    // Input word function codes
    localparam logic FUNC_TICK       = 1'b0;
    localparam logic FUNC_SET_TARGET = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPDATE_INTERVAL = 4'd0,
        REG_STEP_SIZE       = 4'd1,
        REG_MIN_LIMIT_0     = 4'd2,
        REG_MIN_LIMIT_1     = 4'd3,
        REG_MIN_LIMIT_2     = 4'd4,
        REG_MAX_LIMIT_0     = 4'd5,
        REG_MAX_LIMIT_1     = 4'd6,
        REG_MAX_LIMIT_2     = 4'd7
    } reg_index_t;

    typedef struct packed {
        logic                func;
        logic [CH_IDX_W-1:0] servo_index;
        logic [POS_W-1:0]    target_value;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0] position_0;
        logic [POS_W-1:0] position_1;
        logic [POS_W-1:0] position_2;
        logic             updated;
        logic             all_settled;
    } out_word_t;

endpackage

[design/three_channel_servo_slew_limiter_top.sv]
// ---------------------------------------------------------------------------
// three_channel_servo_slew_limiter_top
// Three servo channels ramp toward clamped targets, one step per update
// interval of millisecond ticks.
// ---------------------------------------------------------------------------
//
//  channel   ports                             direction  word
//  --------  --------------------------------  ---------  -----------------
//  input     s_valid s_ready s_data            in         tcssl_pkg::in_word_t
//  result    m_valid m_ready m_data            out        tcssl_pkg::out_word_t
//  config    cfg_valid cfg_ready cfg_index     in         8-bit register data
//            cfg_data
//
//  One word per cycle while m_ready is not stalled: each accepted word is worked
//  in a single pass through the clamp / step logic straight into the result register.
//  A new word is taken whenever the result register is empty or being taken
//  in the same cycle, so stalls on m_ready hold s_ready low.
//  Config writes are always taken (cfg_ready high); indexes above 7 are dropped.
//  Synchronous active-low reset restores limits, interval, step, home
//  positions and clears the elapsed counter; no clearing pass.
// ---------------------------------------------------------------------------

`include "three_channel_servo_slew_limiter_top_macros.svh"

module three_channel_servo_slew_limiter_top (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // input words
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  tcssl_pkg::in_word_t                       s_data,
    // result words
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output tcssl_pkg::out_word_t                      m_data,
    // register writes
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [tcssl_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [tcssl_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int NCH = tcssl_pkg::NUM_CHANNELS;
    localparam int PW  = tcssl_pkg::POS_W;

    // Configuration registers
    logic [PW-1:0] update_interval_reg;
    logic [PW-1:0] step_size_reg;
    logic [PW-1:0] min_limit_reg [NCH];
    logic [PW-1:0] max_limit_reg [NCH];

    // Channel state
    logic [PW-1:0] cur_pos_reg  [NCH];
    logic [PW-1:0] cur_pos_next [NCH];
    logic [PW-1:0] tgt_pos_reg  [NCH];
    logic [PW-1:0] tgt_pos_next [NCH];
    logic [PW-1:0] elapsed_reg;
    logic [PW-1:0] elapsed_next;

    // Result register
    logic                  m_valid_reg;
    tcssl_pkg::out_word_t  m_data_reg;
    tcssl_pkg::out_word_t  m_data_next;

    logic          s_fire;
    logic          do_update;
    logic          settled;
    logic [PW-1:0] elapsed_inc;
    logic [PW-1:0] span   [NCH];
    logic [PW-1:0] move   [NCH];

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            update_interval_reg <= tcssl_pkg::RESET_INTERVAL;
            step_size_reg       <= tcssl_pkg::RESET_STEP;
            for (int i = 0; i < NCH; i++) begin
                min_limit_reg[i] <= tcssl_pkg::RESET_MIN_LIMIT;
                max_limit_reg[i] <= tcssl_pkg::RESET_MAX_LIMIT;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                tcssl_pkg::REG_UPDATE_INTERVAL: update_interval_reg <= cfg_data;
                tcssl_pkg::REG_STEP_SIZE:       step_size_reg       <= cfg_data;
                tcssl_pkg::REG_MIN_LIMIT_0:     min_limit_reg[0]    <= cfg_data;
                tcssl_pkg::REG_MIN_LIMIT_1:     min_limit_reg[1]    <= cfg_data;
                tcssl_pkg::REG_MIN_LIMIT_2:     min_limit_reg[2]    <= cfg_data;
                tcssl_pkg::REG_MAX_LIMIT_0:     max_limit_reg[0]    <= cfg_data;
                tcssl_pkg::REG_MAX_LIMIT_1:     max_limit_reg[1]    <= cfg_data;
                tcssl_pkg::REG_MAX_LIMIT_2:     max_limit_reg[2]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tick counter: saturating increment, cleared on update
    always_comb begin
        elapsed_inc  = (elapsed_reg < tcssl_pkg::ELAPSED_CEILING) ?
                       elapsed_reg + 1'b1 : elapsed_reg;
        do_update    = 1'b0;
        elapsed_next = elapsed_reg;
        if (s_data.func == tcssl_pkg::FUNC_TICK) begin
            if (elapsed_inc >= update_interval_reg) begin
                do_update    = 1'b1;
                elapsed_next = '0;
            end else begin
                elapsed_next = elapsed_inc;
            end
        end
    end

    // Per-channel target clamp and slew step
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            tgt_pos_next[i] = tgt_pos_reg[i];
            if (s_data.func == tcssl_pkg::FUNC_SET_TARGET &&
                s_data.servo_index == tcssl_pkg::CH_IDX_W'(i)) begin
                // when limits cross, a target below min gets min, any other gets max
                if (s_data.target_value < min_limit_reg[i])
                    tgt_pos_next[i] = min_limit_reg[i];
                else if (s_data.target_value > max_limit_reg[i])
                    tgt_pos_next[i] = max_limit_reg[i];
                else
                    tgt_pos_next[i] = s_data.target_value;
            end

            span[i] = (tgt_pos_reg[i] > cur_pos_reg[i]) ?
                      tgt_pos_reg[i] - cur_pos_reg[i] :
                      cur_pos_reg[i] - tgt_pos_reg[i];
            move[i] = (span[i] >= step_size_reg) ? step_size_reg : span[i];

            cur_pos_next[i] = cur_pos_reg[i];
            if (do_update) begin
                if (tgt_pos_reg[i] > cur_pos_reg[i])
                    cur_pos_next[i] = cur_pos_reg[i] + move[i];
                else
                    cur_pos_next[i] = cur_pos_reg[i] - move[i];
            end
        end
    end

    // Result word
    always_comb begin
        settled = 1'b1;
        for (int i = 0; i < NCH; i++) begin
            if (cur_pos_next[i] != tgt_pos_next[i])
                settled = 1'b0;
        end
        m_data_next.position_0  = cur_pos_next[0];
        m_data_next.position_1  = cur_pos_next[1];
        m_data_next.position_2  = cur_pos_next[2];
        m_data_next.updated     = do_update;
        m_data_next.all_settled = settled;
    end

    // State update on accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            for (int i = 0; i < NCH; i++) begin
                cur_pos_reg[i] <= tcssl_pkg::HOME_POSITION;
                tgt_pos_reg[i] <= tcssl_pkg::HOME_POSITION;
            end
        end else if (s_fire) begin
            elapsed_reg <= elapsed_next;
            for (int i = 0; i < NCH; i++) begin
                cur_pos_reg[i] <= cur_pos_next[i];
                tgt_pos_reg[i] <= tgt_pos_next[i];
            end
        end
    end

    // Output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // Checks
    `TCSSL_ASSERT_IMPL(a_no_take_when_stalled, m_valid_reg && !m_ready, !s_ready,
        "input word taken while result is stalled")
    `TCSSL_ASSERT_NEXT(a_set_never_updates,
        s_fire && s_data.func == tcssl_pkg::FUNC_SET_TARGET, !m_data_reg.updated,
        "set-target word reported an update")
    `TCSSL_ASSERT_NEXT(a_update_clears_count, s_fire && do_update,
        elapsed_reg == '0 && m_data_reg.updated,
        "update did not clear elapsed count")
    `TCSSL_ASSERT_NEXT(a_step_zero_frozen, s_fire && step_size_reg == '0,
        cur_pos_reg[0] == $past(cur_pos_reg[0]) &&
        cur_pos_reg[1] == $past(cur_pos_reg[1]) &&
        cur_pos_reg[2] == $past(cur_pos_reg[2]),
        "position moved with step size zero")

endmodule

[test/three_channel_servo_slew_limiter_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the three-channel servo slew limiter
// Words on the input channel are queued by a stimulus process and sent by a
// clocked driver with random gaps. A clocked monitor stalls the result
// channel at random. The driver runs a local copy of the servo state to
// predict each result, and the monitor checks every result word against it.
// Registers are rewritten between phases while nothing is in flight.
// ---------------------------------------------------------------------------
module three_channel_servo_slew_limiter_top_tb;

    localparam int PW  = tcssl_pkg::POS_W;
    localparam int NCH = tcssl_pkg::NUM_CHANNELS;
    localparam int CHW = tcssl_pkg::CH_IDX_W;
    localparam int CIW = tcssl_pkg::CFG_IDX_W;
    localparam int CDW = tcssl_pkg::CFG_DATA_W;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;
    localparam logic [CIW-1:0] CFG_IDX_UNUSED_FIRST = 4'd8;
    localparam logic [CIW-1:0] CFG_IDX_UNUSED_LAST = 4'd15;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    tcssl_pkg::in_word_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    tcssl_pkg::out_word_t m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CIW-1:0]       cfg_index = '0;
    logic [CDW-1:0]       cfg_data = '0;

    // Servo state and registers as the block should hold them
    logic [PW-1:0] pos_now [NCH];
    logic [PW-1:0] pos_goal [NCH];
    logic [PW-1:0] lim_lo [NCH];
    logic [PW-1:0] lim_hi [NCH];
    logic [PW-1:0] ms_count;
    logic [PW-1:0] interval_ms;
    logic [PW-1:0] step_max;

    tcssl_pkg::in_word_t  pending_words[$];
    tcssl_pkg::out_word_t expected_positions[$];
    int        bad_words = 0;
    int        cycle_count = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        quiet_phase = 1'b0;

    three_channel_servo_slew_limiter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Apply one input word to the servo state, return the result it gives
    function automatic tcssl_pkg::out_word_t advance_servos(tcssl_pkg::in_word_t w);
        logic [PW-1:0] span;
        logic [PW-1:0] mv;
        tcssl_pkg::out_word_t r;
        r = '0;
        if (w.func == tcssl_pkg::FUNC_SET_TARGET) begin
            // channel index three is dropped; when limits cross, below min gets min, else max
            if (w.servo_index < NCH) begin
                if (w.target_value < lim_lo[w.servo_index])
                    pos_goal[w.servo_index] = lim_lo[w.servo_index];
                else if (w.target_value > lim_hi[w.servo_index])
                    pos_goal[w.servo_index] = lim_hi[w.servo_index];
                else
                    pos_goal[w.servo_index] = w.target_value;
            end
        end else begin
            if (ms_count != tcssl_pkg::ELAPSED_CEILING)
                ms_count = ms_count + 1'b1;
            if (ms_count >= interval_ms) begin
                for (int i = 0; i < NCH; i++) begin
                    span = (pos_goal[i] > pos_now[i]) ? pos_goal[i] - pos_now[i]
                                                      : pos_now[i] - pos_goal[i];
                    mv = (span >= step_max) ? step_max : span;
                    if (pos_goal[i] > pos_now[i])
                        pos_now[i] = pos_now[i] + mv;
                    else
                        pos_now[i] = pos_now[i] - mv;
                end
                ms_count = '0;
                r.updated = 1'b1;
            end
        end
        r.all_settled = 1'b1;
        for (int i = 0; i < NCH; i++)
            if (pos_now[i] != pos_goal[i]) r.all_settled = 1'b0;
        r.position_0 = pos_now[0];
        r.position_1 = pos_now[1];
        r.position_2 = pos_now[2];
        return r;
    endfunction

    // Mostly short waits, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random position with the extremes weighted up
    function automatic logic [PW-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return PW'($urandom_range(0, 255));
    endfunction

    function automatic void push_word(logic func, logic [CHW-1:0] ch,
                                      logic [PW-1:0] value);
        tcssl_pkg::in_word_t w;
        w.func = func;
        w.servo_index = ch;
        w.target_value = value;
        pending_words.push_back(w);
    endfunction

    // Called at a rising edge; returns at the edge that takes the write
    task automatic write_register(logic [CIW-1:0] idx, logic [CDW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            tcssl_pkg::REG_UPDATE_INTERVAL: interval_ms = val;
            tcssl_pkg::REG_STEP_SIZE:       step_max = val;
            tcssl_pkg::REG_MIN_LIMIT_0:     lim_lo[0] = val;
            tcssl_pkg::REG_MIN_LIMIT_1:     lim_lo[1] = val;
            tcssl_pkg::REG_MIN_LIMIT_2:     lim_lo[2] = val;
            tcssl_pkg::REG_MAX_LIMIT_0:     lim_hi[0] = val;
            tcssl_pkg::REG_MAX_LIMIT_1:     lim_hi[1] = val;
            tcssl_pkg::REG_MAX_LIMIT_2:     lim_hi[2] = val;
            default: ;  // indexes above seven are dropped
        endcase
    endtask

    // Returns at a rising edge once nothing is queued or in flight
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_positions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Input driver: predicts each word as it is taken, then loads the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_positions.push_back(advance_servos(s_data));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_data  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                    send_gap = quiet_phase ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and word checks
    always @(posedge aclk) begin
        tcssl_pkg::out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    bad_words++;
                    if (bad_words <= REPORT_LIMIT)
                        $display("unexpected result word: pos %0d %0d %0d upd %0b settled %0b",
                                 m_data.position_0, m_data.position_1, m_data.position_2,
                                 m_data.updated, m_data.all_settled);
                end else begin
                    want = expected_positions.pop_front();
                    if (m_data.position_0 !== want.position_0 ||
                        m_data.position_1 !== want.position_1 ||
                        m_data.position_2 !== want.position_2 ||
                        m_data.updated !== want.updated ||
                        m_data.all_settled !== want.all_settled) begin
                        bad_words++;
                        if (bad_words <= REPORT_LIMIT) begin
                            $display("mismatch: expected pos %0d %0d %0d upd %0b settled %0b",
                                     want.position_0, want.position_1, want.position_2,
                                     want.updated, want.all_settled);
                            $display("          got      pos %0d %0d %0d upd %0b settled %0b",
                                     m_data.position_0, m_data.position_1,
                                     m_data.position_2, m_data.updated,
                                     m_data.all_settled);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic [PW-1:0] new_interval;
        logic [PW-1:0] new_step;
        logic [PW-1:0] new_lo [NCH];
        logic [PW-1:0] new_hi [NCH];
        int n_items;
        int tick_pct;

        interval_ms = tcssl_pkg::RESET_INTERVAL;
        step_max = tcssl_pkg::RESET_STEP;
        ms_count = '0;
        for (int i = 0; i < NCH; i++) begin
            lim_lo[i] = tcssl_pkg::RESET_MIN_LIMIT;
            lim_hi[i] = tcssl_pkg::RESET_MAX_LIMIT;
            pos_now[i] = tcssl_pkg::HOME_POSITION;
            pos_goal[i] = tcssl_pkg::HOME_POSITION;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: extreme targets, dropped index, first update on tick 20
        push_word(tcssl_pkg::FUNC_SET_TARGET, 2'd0, 8'd255);
        push_word(tcssl_pkg::FUNC_SET_TARGET, 2'd1, 8'd0);
        push_word(tcssl_pkg::FUNC_SET_TARGET, 2'd2, tcssl_pkg::HOME_POSITION);
        push_word(tcssl_pkg::FUNC_SET_TARGET, 2'd3, 8'd0);
        for (int i = 0; i < 21; i++)
            push_word(tcssl_pkg::FUNC_TICK, 2'(i), PW'(i * 12));

        for (int p = 0; p < 10; p++) begin
            wait_idle();
            case (p)
                0: begin
                    // every tick moves all the way; crossed limits on channel 0
                    new_interval = '0;
                    new_step = '1;
                    new_lo = '{8'd255, 8'd0, 8'd100};
                    new_hi = '{8'd0, 8'd255, 8'd100};
                end
                1: begin
                    // slowest updates and frozen motion
                    new_interval = '1;
                    new_step = '0;
                    new_lo = '{8'd0, 8'd0, 8'd0};
                    new_hi = '{8'd255, 8'd255, 8'd255};
                end
                default: begin
                    new_interval = ($urandom_range(0, 9) < 7) ? PW'($urandom_range(0, 6))
                                                              : pick_position();
                    new_step = ($urandom_range(0, 1) == 0) ? PW'($urandom_range(0, 8))
                                                           : pick_position();
                    for (int i = 0; i < NCH; i++) begin
                        new_lo[i] = ($urandom_range(0, 2) == 0) ? '0 : pick_position();
                        new_hi[i] = ($urandom_range(0, 2) == 0) ? '1 : pick_position();
                    end
                end
            endcase
            write_register(tcssl_pkg::REG_UPDATE_INTERVAL, new_interval);
            write_register(tcssl_pkg::REG_STEP_SIZE, new_step);
            write_register(tcssl_pkg::REG_MIN_LIMIT_0, new_lo[0]);
            write_register(tcssl_pkg::REG_MIN_LIMIT_1, new_lo[1]);
            write_register(tcssl_pkg::REG_MIN_LIMIT_2, new_lo[2]);
            write_register(tcssl_pkg::REG_MAX_LIMIT_0, new_hi[0]);
            write_register(tcssl_pkg::REG_MAX_LIMIT_1, new_hi[1]);
            write_register(tcssl_pkg::REG_MAX_LIMIT_2, new_hi[2]);
            if (p == 0 || $urandom_range(0, 2) == 0)
                write_register(CIW'($urandom_range(CFG_IDX_UNUSED_FIRST,
                                                   CFG_IDX_UNUSED_LAST)),
                               pick_position());
            cfg_valid <= 1'b0;

            // some phases run with no gaps and no stalls
            quiet_phase = (p % 3 == 2);
            n_items = (p == 1) ? 300 : 80;
            tick_pct = (p == 1) ? 90 : 55;
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 99) < tick_pct)
                    push_word(tcssl_pkg::FUNC_TICK, CHW'($urandom_range(0, 3)),
                              pick_position());
                else
                    push_word(tcssl_pkg::FUNC_SET_TARGET, CHW'($urandom_range(0, 3)),
                              pick_position());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (bad_words == 0 && expected_positions.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
